[rtl/lge_pkg.sv]
// Shared types and constants for the luma gradient edge mask.
`default_nettype none
package lge_pkg;

  // Q16 luma weights
  localparam logic [15:0] W_RED   = 16'd19589;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  // Register reset values
  localparam logic [7:0]  EDGE_THRESHOLD_RESET = 8'd160;
  localparam int          LINE_WIDTH_RESET     = 640;
  localparam int          MIN_WIDTH            = 3;

  // Output queue depth, room for two words per item plus slack
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QW          = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  WHITE = 8'd255;
  localparam logic [7:0]  BLACK = 8'd0;

  typedef enum logic [0:0] {
    CFG_EDGE_THRESHOLD = 1'b0,
    CFG_LINE_WIDTH     = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       row_end;
    logic       last_of_run;
  } result_t;

  // Words pushed into the output queue by one item (count 0..2)
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage
`default_nettype wire

[rtl/luma_gradient_edge_mask_top.sv]
// Top level of the luma gradient edge mask: gray conversion, edge decision, output queue.
// Words released by an item pass through the input register and then the output queue
// before they are offered. Throughput: one pixel per clock while the queue has room;
// the first pixel of a row yields no word and the last yields two, and a four-word
// output queue absorbs that burst.
// Reset (rst, synchronous): column count, gray history and queue cleared; threshold 160,
// line width 640 (clamped to MAX_WIDTH).
`default_nettype none
module luma_gradient_edge_mask_top
  import lge_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // pixel input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire pixel_t      in_pixel,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output result_t          out_pixel,
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire cfg_index_t  cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RESET_EFF = (LINE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RESET;
  localparam logic [CW-1:0] RESET_LAST = CW'(RESET_EFF - 1);
  localparam logic [CW-1:0] MAX_LAST   = CW'(MAX_WIDTH - 1);
  localparam logic [CW-1:0] MIN_LAST   = CW'(MIN_WIDTH - 1);

  // configuration registers
  logic [7:0]    edge_threshold;
  logic [CW-1:0] width_last;
  logic [CW-1:0] width_last_next;

  // input stage
  logic          s1_valid;
  pixel_t        s1_pixel;
  logic [23:0]   s1_prod_r;
  logic [23:0]   s1_prod_g;
  logic [23:0]   s1_prod_b;
  logic          s1_adv;

  // row state
  logic [CW-1:0] column_count;
  logic [7:0]    gray_prev;
  logic [7:0]    gray_prev2;
  pixel_t        held_pixel;

  logic [23:0]   luma_sum;
  logic [7:0]    gray;
  logic [7:0]    diff;
  logic          last_col;
  logic          has_inner;
  result_t       inner_word;
  result_t       border_word;
  push_t         push;
  logic          pop;
  logic [QW:0]   fill;

  assign cfg_ready = 1'b1;

  // effective width minus one, clamped at write time
  always_comb begin
    if (cfg_data < 13'(MIN_WIDTH)) begin
      width_last_next = MIN_LAST;
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      width_last_next = MAX_LAST;
    end else begin
      width_last_next = CW'(cfg_data - 13'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= EDGE_THRESHOLD_RESET;
      width_last     <= RESET_LAST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EDGE_THRESHOLD: edge_threshold <= cfg_data[7:0];
        CFG_LINE_WIDTH:     width_last     <= width_last_next;
        default:            ;
      endcase
    end
  end

  // input register with weighted channels
  assign s1_adv   = s1_valid && (32'(fill) <= QUEUE_DEPTH - 2);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_pixel  <= in_pixel;
      s1_prod_r <= {8'd0, W_RED}   * {16'd0, in_pixel.red};
      s1_prod_g <= {8'd0, W_GREEN} * {16'd0, in_pixel.green};
      s1_prod_b <= {8'd0, W_BLUE}  * {16'd0, in_pixel.blue};
    end
  end

  // gray value and edge decision
  always_comb begin
    luma_sum  = s1_prod_r + s1_prod_g + s1_prod_b;
    gray      = luma_sum[23:16];
    diff      = (gray >= gray_prev2) ? (gray - gray_prev2) : (gray_prev2 - gray);
    last_col  = column_count >= width_last;
    has_inner = column_count != '0;

    // finished inner pixel, or the row's first pixel unchanged
    if (column_count == CW'(1)) begin
      inner_word.out_red   = held_pixel.red;
      inner_word.out_green = held_pixel.green;
      inner_word.out_blue  = held_pixel.blue;
    end else begin
      inner_word.out_red   = (diff > edge_threshold) ? WHITE : BLACK;
      inner_word.out_green = (diff > edge_threshold) ? WHITE : BLACK;
      inner_word.out_blue  = (diff > edge_threshold) ? WHITE : BLACK;
    end
    inner_word.row_end     = 1'b0;
    inner_word.last_of_run = !last_col;

    // last pixel of the row, unchanged
    border_word.out_red     = s1_pixel.red;
    border_word.out_green   = s1_pixel.green;
    border_word.out_blue    = s1_pixel.blue;
    border_word.row_end     = 1'b1;
    border_word.last_of_run = 1'b1;

    push.count  = s1_adv ? (2'(has_inner) + 2'(last_col)) : 2'd0;
    push.first  = has_inner ? inner_word : border_word;
    push.second = border_word;
  end

  // row state update
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      gray_prev    <= '0;
      gray_prev2   <= '0;
      held_pixel   <= '0;
    end else if (s1_adv) begin
      column_count <= last_col ? '0 : column_count + CW'(1);
      gray_prev2   <= gray_prev;
      gray_prev    <= gray;
      held_pixel   <= s1_pixel;
    end
  end

  // output queue
  assign pop       = out_valid && !out_stall;
  assign out_valid = fill != '0;

  lge_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (out_pixel),
    .fill (fill)
  );

  // checks
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0 && push.first.row_end) |-> push.first.last_of_run)
    else $error("row end word not marked last");
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> (!push.first.last_of_run && push.second.row_end))
    else $error("two-word item in wrong order");
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    s1_adv && last_col |=> column_count == '0)
    else $error("column count did not wrap at row end");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && 32'(fill) > QUEUE_DEPTH - 2))
    else $error("input stalled without a full queue");

endmodule
`default_nettype wire

[rtl/lge_queue.sv]
// Output queue: takes up to two result words per cycle, gives one per cycle when popped.
`default_nettype none
module lge_queue
  import lge_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire push_t   push,
  input  wire logic    pop,
  output result_t      head,
  output logic [QW:0]  fill
);

  result_t         mem [QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [QW-1:0]   wr_ptr_next;
  logic [QW:0]     fill_next;

  always_comb begin
    wr_ptr_next = wr_ptr + QW'(push.count);
    fill_next   = fill + (QW+1)'(push.count) - (QW+1)'(pop);
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QW'(1)] <= push.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr + QW'(pop);
      fill   <= fill_next;
    end
  end

  assign head = mem[rd_ptr];

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (32'(fill) + 32'(push.count)) <= QUEUE_DEPTH)
    else $error("output queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> fill != '0)
    else $error("output queue underflow");
  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    ##1 !$past(rst) |-> fill == $past(fill_next))
    else $error("queue fill level out of step");

endmodule
`default_nettype wire
